// ===== hw/rtl/insertion_sorter_top_defines.svh =====
// Assertion macros used by the sorter cell row (isort_dp).
`ifndef INSERTION_SORTER_TOP_DEFINES_SVH
`define INSERTION_SORTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/isort_pkg.sv =====
package isort_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int VALUE_W      = 32;

    // Commands from the controller to the cell row.
    typedef struct packed {
        logic insert;     // take the input value (dropped when full)
        logic shift_out;  // head value transferred, move the row down
    } t_dp_cmd;

    // Status from the cell row back to the controller.
    typedef struct packed {
        logic last_one;   // exactly one value left
    } t_dp_status;

endpackage

// ===== hw/rtl/isort_dp.sv =====
`include "insertion_sorter_top_defines.svh"

module isort_dp
    import isort_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [VALUE_W-1:0]  i_value,
    output t_dp_status                 o_status,
    output logic signed [VALUE_W-1:0]  o_sorted_value,
    output logic                       o_dropped
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_cell [CAPACITY];
    logic signed [VALUE_W-1:0] n_cell [CAPACITY];
    logic [CW-1:0]             r_count, n_count;
    logic                      r_overflow, n_overflow;
    logic [CAPACITY-1:0]       w_gt;
    logic                      w_full;
    logic                      w_store;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_store = i_cmd.insert && !w_full;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            // Held cell whose value sits strictly above the new one.
            assign w_gt[gi] = (CW'(gi) < r_count) && (r_cell[gi] > i_value);

            always_comb begin
                n_cell[gi] = r_cell[gi];
                if (w_store) begin
                    if (gi == 0) begin
                        if (w_gt[gi] || (r_count == CW'(gi))) begin
                            n_cell[gi] = i_value;
                        end
                    end else begin
                        if (w_gt[(gi > 0) ? gi - 1 : 0]) begin
                            n_cell[gi] = r_cell[(gi > 0) ? gi - 1 : 0];
                        end else if (w_gt[gi] || (r_count == CW'(gi))) begin
                            n_cell[gi] = i_value;
                        end
                    end
                end else if (i_cmd.shift_out) begin
                    if (gi < CAPACITY - 1) begin
                        n_cell[gi] = r_cell[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_cell[gi] <= n_cell[gi];
            end
        end
    endgenerate

    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        if (i_cmd.insert) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.shift_out) begin
            n_count = r_count - CW'(1);
            // Set ends with this transfer: clear the drop flag too.
            if (r_count == CW'(1)) begin
                n_overflow = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    assign o_status.last_one = (r_count == CW'(1));
    assign o_sorted_value    = r_cell[0];
    assign o_dropped         = r_overflow;

    `ISORT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
        "held count above capacity")
    `ISORT_ASSERT_SAME(a_shift_nonempty, i_clk, i_rst_n, i_cmd.shift_out, r_count != '0,
        "transfer from an empty row")
    `ISORT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_cmd.insert && !w_full,
        r_count == $past(r_count) + CW'(1), "stored value not counted")
    `ISORT_ASSERT_NEXT(a_run_clears, i_clk, i_rst_n,
        i_cmd.shift_out && (r_count == CW'(1)), (r_count == '0) && !r_overflow,
        "row not cleared after final transfer")

endmodule

// ===== hw/rtl/isort_ctrl.sv =====
module isort_ctrl
    import isort_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_last,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output logic       o_stall,
    output logic       o_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_COLLECT,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   w_in_xfer;
    logic   w_out_xfer;

    assign w_in_xfer  = i_valid && (r_state == S_COLLECT);
    assign w_out_xfer = (r_state == S_EMIT) && !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_COLLECT: begin
                if (w_in_xfer && i_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_xfer && i_status.last_one) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold off new values while the set drains.
    assign o_stall         = (r_state != S_COLLECT);
    assign o_valid         = (r_state == S_EMIT);
    assign o_cmd.insert    = w_in_xfer;
    assign o_cmd.shift_out = w_out_xfer;

endmodule

// ===== hw/rtl/insertion_sorter_top.sv =====
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_value, i_last
// output    out        o_valid / i_stall    o_sorted_value, o_run_end, o_dropped
//
// A value not marked last is inserted by a row of compare-and-shift cells.
// A last value is inserted, then the held values (at most CAPACITY) are emitted, one per
// output transfer, as the row moves down into its head cell.
// Reset clears the held count, the drop flag and the controller; cell contents are kept.
// i_stall holds the head value in place; the input is stalled for the whole emission.
module insertion_sorter_top
    import isort_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_sorted_value,
    output logic                      o_run_end,
    output logic                      o_dropped
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    isort_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_cmd    (w_cmd)
    );

    isort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .o_status       (w_status),
        .o_sorted_value (o_sorted_value),
        .o_dropped      (o_dropped)
    );

    assign o_run_end = w_status.last_one;

endmodule
